// ===== rtl/ertsu_pkg.sv =====
// shared constants, codes and control structs for the refractory time surface unit
// no dependencies; every other rtl file refers to this package by scoped names
`default_nettype none

package ertsu_pkg;

	// default sensor geometry, overridable at the top level
	localparam int MAX_WIDTH_DEF  = 512;
	localparam int MAX_HEIGHT_DEF = 512;

	// surface format: unsigned q1.FRACTION_BITS
	localparam int FRACTION_BITS = 16;
	localparam int SURF_W        = FRACTION_BITS + 1;

	// field widths
	localparam int CMD_W      = 2;
	localparam int COORD_W    = 9;
	localparam int TIME_W     = 48;
	localparam int LEN_W      = 32;
	localparam int STATUS_W   = 3;
	localparam int REFR_W     = 24;
	localparam int DIM_W      = 10;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;

	// window tag kept with every pixel word
	localparam int EPOCH_W = 8;
	localparam logic [EPOCH_W-1:0] EPOCH_CLEAR = '0;
	localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
	localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;

	localparam logic [SURF_W-1:0] SURF_ONE = SURF_W'(1) << FRACTION_BITS;

	// command codes (any other code behaves as a surface read)
	localparam logic [CMD_W-1:0] CMD_START = 2'd0;
	localparam logic [CMD_W-1:0] CMD_EVENT = 2'd1;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_STARTED    = 3'd0;
	localparam logic [STATUS_W-1:0] ST_WRITTEN    = 3'd1;
	localparam logic [STATUS_W-1:0] ST_SUPPRESSED = 3'd2;
	localparam logic [STATUS_W-1:0] ST_READ_DONE  = 3'd3;
	localparam logic [STATUS_W-1:0] ST_RANGE      = 3'd4;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_REFRACTORY    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_HEIGHT = 2'd2;

	localparam logic [REFR_W-1:0] REFR_RESET = 24'd1000;
	localparam logic [DIM_W-1:0]  DIM_RESET  = 10'd512;

	// one word of the pixel memory
	typedef struct packed {
		logic [EPOCH_W-1:0] tag;
		logic [TIME_W-1:0]  last_time;
		logic               last_pol;
		logic [SURF_W-1:0]  surface;
	} pix_word_t;

	// controller to datapath
	typedef struct packed {
		logic item_ready;
		logic addr_phase;
		logic read_phase;
		logic test_phase;
		logic mem_write;
		logic clear_step;
		logic load_out;
	} ctl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_start;
		logic out_of_range;
		logic pass_div;
		logic pass_direct;
		logic div_done;
		logic clear_done;
		logic wrap;
		logic out_free;
	} dp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/ertsu_if.sv =====
// valid/ready channel interfaces: input items, result items, configuration writes
// depends on ertsu_pkg for field widths
`default_nettype none

interface ertsu_in_if;
	logic                                valid;
	logic                                ready;
	logic [ertsu_pkg::CMD_W-1:0]         command;
	logic [ertsu_pkg::COORD_W-1:0]       pixel_x;
	logic [ertsu_pkg::COORD_W-1:0]       pixel_y;
	logic                                event_polarity;
	logic [ertsu_pkg::TIME_W-1:0]        time_us;
	logic [ertsu_pkg::LEN_W-1:0]         window_length_us;

	modport source (
		output valid, command, pixel_x, pixel_y, event_polarity, time_us, window_length_us,
		input  ready
	);
	modport sink (
		input  valid, command, pixel_x, pixel_y, event_polarity, time_us, window_length_us,
		output ready
	);
endinterface

interface ertsu_out_if;
	logic                           valid;
	logic                           ready;
	logic [ertsu_pkg::STATUS_W-1:0] status;
	logic [ertsu_pkg::SURF_W-1:0]   surface_value;

	modport source (output valid, status, surface_value, input ready);
	modport sink (input valid, status, surface_value, output ready);
endinterface

interface ertsu_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [ertsu_pkg::CFG_IDX_W-1:0]  index;
	logic [ertsu_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/ertsu_div.sv =====
// restoring divider, one quotient bit per cycle, for the surface normalization
// depends on ertsu_pkg; dividend must be below divisor
`default_nettype none

module ertsu_div (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic [ertsu_pkg::LEN_W-1:0]          dividend,
	input  logic [ertsu_pkg::LEN_W-1:0]          divisor,
	output logic                                 done,
	output logic [ertsu_pkg::FRACTION_BITS-1:0] quotient
);

	localparam int LW    = ertsu_pkg::LEN_W;
	localparam int FB    = ertsu_pkg::FRACTION_BITS;
	localparam int CNT_W = $clog2(FB);
	localparam logic [CNT_W-1:0] LAST = CNT_W'(FB - 1);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [LW-1:0]    rem_q;
	logic [FB-1:0]    quot_q;
	logic [LW:0]      trial;
	logic [LW:0]      diff;
	logic             fits;

	assign trial = {rem_q, 1'b0};
	assign diff  = trial - {1'b0, divisor};
	assign fits  = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (cnt_q == LAST) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= dividend;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= fits ? diff[LW-1:0] : trial[LW-1:0];
			quot_q <= {quot_q[FB-2:0], fits};
		end
	end

	// last step in flight; quotient is final on the next cycle
	assign done     = busy_q && (cnt_q == LAST);
	assign quotient = quot_q;

endmodule

`default_nettype wire

// ===== rtl/ertsu_datapath.sv =====
// datapath: item and config registers, pixel memory with window tags,
// refractory test, normalization with the iterative divider, output register
// depends on ertsu_pkg and ertsu_div
`default_nettype none

module ertsu_datapath #(
	parameter int MAX_WIDTH  = ertsu_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = ertsu_pkg::MAX_HEIGHT_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  ertsu_pkg::ctl_cmd_t                 cmd,
	output ertsu_pkg::dp_stat_t                 stat,
	input  logic                                item_valid,
	input  logic [ertsu_pkg::CMD_W-1:0]         command,
	input  logic [ertsu_pkg::COORD_W-1:0]       pixel_x,
	input  logic [ertsu_pkg::COORD_W-1:0]       pixel_y,
	input  logic                                event_polarity,
	input  logic [ertsu_pkg::TIME_W-1:0]        time_us,
	input  logic [ertsu_pkg::LEN_W-1:0]         window_length_us,
	input  logic                                cfg_we,
	input  logic [ertsu_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ertsu_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                                out_ready,
	output logic                                out_valid,
	output logic [ertsu_pkg::STATUS_W-1:0]      status,
	output logic [ertsu_pkg::SURF_W-1:0]        surface_value
);

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int TW    = ertsu_pkg::TIME_W;
	localparam int LW    = ertsu_pkg::LEN_W;
	localparam int SW    = ertsu_pkg::SURF_W;
	localparam int FB    = ertsu_pkg::FRACTION_BITS;
	localparam logic [AW-1:0] ROW_PITCH = AW'(MAX_WIDTH);
	localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

	// captured item
	logic [ertsu_pkg::CMD_W-1:0]   cmd_q;
	logic [ertsu_pkg::COORD_W-1:0] x_q;
	logic [ertsu_pkg::COORD_W-1:0] y_q;
	logic                          pol_q;
	logic [TW-1:0]                 ts_q;
	logic [LW-1:0]                 len_q;

	// config and window state
	logic [ertsu_pkg::REFR_W-1:0]  refr_q;
	logic [ertsu_pkg::DIM_W-1:0]   act_w_q;
	logic [ertsu_pkg::DIM_W-1:0]   act_h_q;
	logic [TW-1:0]                 start_q;
	logic [LW-1:0]                 dur_q;
	logic [ertsu_pkg::EPOCH_W-1:0] epoch_q;
	logic                          wrap_q;
	logic [AW-1:0]                 clr_addr_q;

	// pixel memory and lookup
	ertsu_pkg::pix_word_t pix_mem [DEPTH];
	ertsu_pkg::pix_word_t rd_q;
	ertsu_pkg::pix_word_t wr_word;
	logic [AW-1:0]        pix_addr;
	logic [AW-1:0]        addr_q;
	logic [AW-1:0]        wr_addr;
	logic                 wr_en;

	// test and normalization
	logic          hit_q;
	logic [TW:0]   delta_q;
	logic [TW:0]   diff_q;
	logic          use_div_q;
	logic [SW-1:0] direct_q;
	logic          is_event;
	logic          pass;
	logic          val_zero;
	logic          val_sat;
	logic          div_start;
	logic          div_done;
	logic [FB-1:0] div_quot;
	logic [SW-1:0] write_val;

	// result staging and output register
	logic [ertsu_pkg::STATUS_W-1:0] res_status_q;
	logic [SW-1:0]                  res_value_q;
	logic                           out_valid_q;
	logic [ertsu_pkg::STATUS_W-1:0] out_status_q;
	logic [SW-1:0]                  out_value_q;

	// decode and address
	assign is_event          = cmd_q == ertsu_pkg::CMD_EVENT;
	assign stat.is_start     = cmd_q == ertsu_pkg::CMD_START;
	assign stat.out_of_range = ({1'b0, x_q} >= act_w_q) || ({1'b0, y_q} >= act_h_q) ||
		(int'(x_q) >= MAX_WIDTH) || (int'(y_q) >= MAX_HEIGHT);
	assign pix_addr = AW'(y_q) * ROW_PITCH + AW'(x_q);

	// refractory test and normalization cases
	assign pass = !hit_q ||
		(!delta_q[TW] && (delta_q[TW-1:0] > TW'(refr_q))) ||
		(rd_q.last_pol != pol_q);
	assign val_zero = (dur_q == '0) || diff_q[TW];
	assign val_sat  = diff_q[TW-1:0] >= TW'(dur_q);

	assign stat.pass_div    = is_event && pass && !val_zero && !val_sat;
	assign stat.pass_direct = is_event && pass && (val_zero || val_sat);
	assign div_start        = cmd.test_phase && stat.pass_div;

	assign stat.div_done   = div_done;
	assign stat.clear_done = clr_addr_q == LAST_ADDR;
	assign stat.wrap       = wrap_q;
	assign stat.out_free   = !out_valid_q || out_ready;

	assign write_val = use_div_q ? {1'b0, div_quot} : direct_q;

	ertsu_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (diff_q[LW-1:0]),
		.divisor  (dur_q),
		.done     (div_done),
		.quotient (div_quot)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			refr_q      <= ertsu_pkg::REFR_RESET;
			act_w_q     <= ertsu_pkg::DIM_RESET;
			act_h_q     <= ertsu_pkg::DIM_RESET;
			start_q     <= '0;
			dur_q       <= '0;
			epoch_q     <= ertsu_pkg::EPOCH_FIRST;
			wrap_q      <= 1'b0;
			clr_addr_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					ertsu_pkg::REG_REFRACTORY:    refr_q  <= cfg_data[ertsu_pkg::REFR_W-1:0];
					ertsu_pkg::REG_ACTIVE_WIDTH:  act_w_q <= cfg_data[ertsu_pkg::DIM_W-1:0];
					ertsu_pkg::REG_ACTIVE_HEIGHT: act_h_q <= cfg_data[ertsu_pkg::DIM_W-1:0];
					default: ;
				endcase
			end
			if (cmd.addr_phase) begin
				wrap_q <= 1'b0;
				if (stat.is_start) begin
					start_q <= ts_q;
					dur_q   <= len_q;
					// a new tag invalidates every pixel; tags wrap through a clearing pass
					if (epoch_q == ertsu_pkg::EPOCH_LAST) begin
						epoch_q <= ertsu_pkg::EPOCH_FIRST;
						wrap_q  <= 1'b1;
					end else begin
						epoch_q <= epoch_q + ertsu_pkg::EPOCH_W'(1);
					end
				end
			end
			if (cmd.clear_step) begin
				clr_addr_q <= stat.clear_done ? '0 : clr_addr_q + AW'(1);
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.item_ready && item_valid) begin
			cmd_q <= command;
			x_q   <= pixel_x;
			y_q   <= pixel_y;
			pol_q <= event_polarity;
			ts_q  <= time_us;
			len_q <= window_length_us;
		end
		if (cmd.addr_phase) begin
			addr_q       <= pix_addr;
			res_value_q  <= '0;
			res_status_q <= stat.is_start ? ertsu_pkg::ST_STARTED : ertsu_pkg::ST_RANGE;
		end
		if (cmd.read_phase) begin
			hit_q   <= rd_q.tag == epoch_q;
			delta_q <= {1'b0, ts_q} - {1'b0, rd_q.last_time};
			diff_q  <= {1'b0, ts_q} - {1'b0, start_q};
		end
		if (cmd.test_phase) begin
			use_div_q <= !val_zero && !val_sat;
			direct_q  <= val_zero ? '0 : ertsu_pkg::SURF_ONE;
			if (!is_event) begin
				res_status_q <= ertsu_pkg::ST_READ_DONE;
				res_value_q  <= hit_q ? rd_q.surface : '0;
			end else begin
				res_status_q <= ertsu_pkg::ST_SUPPRESSED;
				res_value_q  <= '0;
			end
		end
		if (cmd.mem_write) begin
			res_status_q <= ertsu_pkg::ST_WRITTEN;
			res_value_q  <= write_val;
		end
		if (cmd.load_out) begin
			out_status_q <= res_status_q;
			out_value_q  <= res_value_q;
		end
	end

	// pixel memory, one write and one registered read port
	always_comb begin
		wr_en   = cmd.mem_write || cmd.clear_step;
		wr_addr = cmd.clear_step ? clr_addr_q : addr_q;
		if (cmd.clear_step) begin
			wr_word     = '0;
			wr_word.tag = ertsu_pkg::EPOCH_CLEAR;
		end else begin
			wr_word.tag       = epoch_q;
			wr_word.last_time = ts_q;
			wr_word.last_pol  = pol_q;
			wr_word.surface   = write_val;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			pix_mem[wr_addr] <= wr_word;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.addr_phase && !stat.out_of_range) begin
			rd_q <= pix_mem[pix_addr];
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = out_status_q;
	assign surface_value = out_value_q;

endmodule

`default_nettype wire

// ===== rtl/ertsu_ctrl.sv =====
// controller: one-hot state machine sequencing clear, lookup, test, divide, write and response
// depends on ertsu_pkg for the command and status structs
`default_nettype none

module ertsu_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	input  ertsu_pkg::dp_stat_t stat,
	output ertsu_pkg::ctl_cmd_t cmd
);

	typedef enum logic [7:0] {
		S_CLEAR = 8'b0000_0001,
		S_IDLE  = 8'b0000_0010,
		S_ADDR  = 8'b0000_0100,
		S_READ  = 8'b0000_1000,
		S_TEST  = 8'b0001_0000,
		S_DIV   = 8'b0010_0000,
		S_WRITE = 8'b0100_0000,
		S_RESP  = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				cmd.clear_step = 1'b1;
				if (stat.clear_done) state_d = S_IDLE;
			end
			S_IDLE: begin
				cmd.item_ready = 1'b1;
				if (item_valid) state_d = S_ADDR;
			end
			S_ADDR: begin
				cmd.addr_phase = 1'b1;
				state_d = (stat.is_start || stat.out_of_range) ? S_RESP : S_READ;
			end
			S_READ: begin
				cmd.read_phase = 1'b1;
				state_d = S_TEST;
			end
			S_TEST: begin
				cmd.test_phase = 1'b1;
				if (stat.pass_div) begin
					state_d = S_DIV;
				end else if (stat.pass_direct) begin
					state_d = S_WRITE;
				end else begin
					state_d = S_RESP;
				end
			end
			S_DIV: begin
				if (stat.div_done) state_d = S_WRITE;
			end
			S_WRITE: begin
				cmd.mem_write = 1'b1;
				state_d = S_RESP;
			end
			S_RESP: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_d = stat.wrap ? S_CLEAR : S_IDLE;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/event_refractory_time_surface_unit.sv =====
// top level of the event refractory time surface unit: controller, datapath, channels
// depends on ertsu_pkg, ertsu_if, ertsu_ctrl, ertsu_datapath (which holds ertsu_div)
`default_nettype none

// Event-camera time surface with a per-pixel refractory filter. Each input beat is a
// window start, an event or a surface read, and produces exactly one result beat. One
// item is processed at a time: a window start or an out-of-range coordinate goes
// straight to the response, a read or a suppressed event adds the memory read and the
// test, an event whose value is 0 or saturated also the write, and an event that
// needs a real quotient also the bit-serial divider (one quotient bit per cycle,
// FRACTION_BITS steps). The pixel state lives in one MAX_WIDTH*MAX_HEIGHT word
// memory with one write and one registered read port; each word carries an 8-bit
// window tag, so a window start invalidates all pixels at once. After reset, and
// after every 255th window start once its result beat is loaded, the unit sweeps the
// memory to clear the tags, one word per cycle, and takes no input beat during the
// sweep. Configuration writes are always taken and must only be issued while idle.
// The result register lets a new item be accepted while the previous result waits.
module event_refractory_time_surface_unit #(
	parameter int MAX_WIDTH  = ertsu_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = ertsu_pkg::MAX_HEIGHT_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	ertsu_in_if.sink     items,
	ertsu_out_if.source  results,
	ertsu_cfg_if.sink    cfg
);

	// control and status between the state machine and the datapath
	ertsu_pkg::ctl_cmd_t cmd;
	ertsu_pkg::dp_stat_t stat;

	// item channel is open only while the controller sits idle
	assign items.ready = cmd.item_ready;

	// config registers are plain flops, a write is always accepted
	assign cfg.ready = 1'b1;

	ertsu_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (items.valid),
		.stat       (stat),
		.cmd        (cmd)
	);

	ertsu_datapath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.stat             (stat),
		.item_valid       (items.valid),
		.command          (items.command),
		.pixel_x          (items.pixel_x),
		.pixel_y          (items.pixel_y),
		.event_polarity   (items.event_polarity),
		.time_us          (items.time_us),
		.window_length_us (items.window_length_us),
		// write strobe qualified by the handshake
		.cfg_we           (cfg.valid && cfg.ready),
		.cfg_index        (cfg.index),
		.cfg_data         (cfg.data),
		.out_ready        (results.ready),
		.out_valid        (results.valid),
		.status           (results.status),
		.surface_value    (results.surface_value)
	);

endmodule

`default_nettype wire
